// ----- src/greedy_text_line_splitter_assert.svh -----
// Assertion macros for the line splitter checkers.
// Both expect signals named clk and arst_n in the scope where they are used.
`ifndef GREEDY_TEXT_LINE_SPLITTER_ASSERT_SVH
`define GREEDY_TEXT_LINE_SPLITTER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GTLS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define GTLS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/gtls_pkg.sv -----
package gtls_pkg;

	localparam int MAX_GLYPHS = 4096;
	localparam int ADDR_W     = $clog2(MAX_GLYPHS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int WIDTH_W    = 24;
	localparam int CODE_W     = 21;

	localparam logic [CODE_W-1:0] SPACE_CODE = CODE_W'(32);

	typedef enum logic [1:0] {
		ST_CHUNK = 2'd0,
		ST_END   = 2'd1,
		ST_NOFIT = 2'd2
	} status_t;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_REQUEST = 1'b1
	} op_t;

	typedef struct packed {
		logic               flag;
		logic [WIDTH_W-1:0] width;
	} glyph_t;

	typedef enum logic {
		SEL_START = 1'b0,
		SEL_INDEX = 1'b1
	} rd_sel_t;

	typedef enum logic [1:0] {
		RES_NONE  = 2'd0,
		RES_END   = 2'd1,
		RES_FINAL = 2'd2
	} res_cmd_t;

	typedef struct packed {
		logic     load;
		logic     latch_req;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     start_inc;
		logic     scan_init;
		logic     scan_step;
		res_cmd_t res;
	} cmd_t;

	typedef struct packed {
		logic start_at_end;
		logic index_at_end;
		logic rd_space;
		logic fits;
		logic skip_left;
		logic word_mode;
		logic chunk_ok;
	} sts_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_PRE_RD,
		S_PRE_EV,
		S_SCAN_RD,
		S_SCAN_EV,
		S_FINISH,
		S_END_OUT,
		S_POST_CK,
		S_POST_RD,
		S_POST_EV
	} state_t;

endpackage

// ----- src/gtls_in_if.sv -----
interface gtls_in_if import gtls_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               operation;
	logic               start_new_text;
	logic [CODE_W-1:0]  glyph_code;
	logic [WIDTH_W-1:0] glyph_width;
	logic [WIDTH_W-1:0] max_space;
	logic               remove_left_spaces;

	modport source (
		output valid, operation, start_new_text, glyph_code, glyph_width,
		       max_space, remove_left_spaces,
		input  ready
	);

	modport sink (
		input  valid, operation, start_new_text, glyph_code, glyph_width,
		       max_space, remove_left_spaces,
		output ready
	);
endinterface

// ----- src/gtls_out_if.sv -----
interface gtls_out_if import gtls_pkg::*; ();
	logic             valid;
	logic             ready;
	status_t          status;
	logic [ADDR_W-1:0] chunk_start;
	logic [CNT_W-1:0] chunk_length;
	logic             break_requested;

	modport source (
		output valid, status, chunk_start, chunk_length, break_requested,
		input  ready
	);

	modport sink (
		input  valid, status, chunk_start, chunk_length, break_requested,
		output ready
	);
endinterface

// ----- src/greedy_text_line_splitter.sv -----
// Greedy line splitter over a stored text of up to 4096 glyphs. A load request
// writes one glyph (space flag and width) into the glyph store, or drops it once
// the store is full. A chunk request reads the glyphs through the single read
// port of the store, whose read is registered: each measured glyph (those that
// fit plus the one that stops the scan) passes a read state and a compare state,
// and each skipped leading or trailing space also a text-end check. One request
// is worked on at a time, and the next one is taken once the controller returns
// to idle, even while the previous result still waits on the result channel. The
// store needs no clearing pass after reset. Write split_mode only while no
// request is open.
module greedy_text_line_splitter import gtls_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	gtls_in_if.sink    item,
	gtls_out_if.source result,
	input  logic       cfg_we,
	input  logic       cfg_data
);

	cmd_t cmd;
	sts_t sts;

	gtls_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item.valid),
		.item_operation (item.operation),
		.item_ready     (item.ready),
		.result_ready   (result.ready),
		.result_valid   (result.valid),
		.cmd            (cmd),
		.sts            (sts)
	);

	gtls_datapath u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_data           (cfg_data),
		.start_new_text     (item.start_new_text),
		.glyph_code         (item.glyph_code),
		.glyph_width        (item.glyph_width),
		.max_space          (item.max_space),
		.remove_left_spaces (item.remove_left_spaces),
		.cmd                (cmd),
		.sts                (sts),
		.res_status         (result.status),
		.res_start          (result.chunk_start),
		.res_length         (result.chunk_length),
		.res_break          (result.break_requested)
	);

endmodule

// ----- src/gtls_datapath.sv -----
module gtls_datapath import gtls_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_data,
	input  logic               start_new_text,
	input  logic [CODE_W-1:0]  glyph_code,
	input  logic [WIDTH_W-1:0] glyph_width,
	input  logic [WIDTH_W-1:0] max_space,
	input  logic               remove_left_spaces,
	input  cmd_t               cmd,
	output sts_t               sts,
	output status_t            res_status,
	output logic [ADDR_W-1:0]  res_start,
	output logic [CNT_W-1:0]   res_length,
	output logic               res_break
);

	glyph_t             mem_q [MAX_GLYPHS];
	glyph_t             rd_q;
	logic [CNT_W-1:0]   len_q;
	logic [CNT_W-1:0]   start_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   brk_q;
	logic [WIDTH_W-1:0] sum_q;
	logic [WIDTH_W-1:0] max_sp_q;
	logic               in_sp_q;
	logic               skip_q;
	logic               mode_q;

	logic [CNT_W-1:0]   wr_base;
	logic               wr_ok;
	logic [CNT_W-1:0]   rd_addr;
	logic [WIDTH_W:0]   sum_next;
	logic [CNT_W-1:0]   brk_fin;
	logic [CNT_W-1:0]   chunk_len;
	logic               idx_end;

	// A fresh text restarts the store at entry zero.
	assign wr_base = start_new_text ? '0 : len_q;
	assign wr_ok   = cmd.load && (wr_base < CNT_W'(MAX_GLYPHS));
	assign rd_addr = (cmd.rd_sel == SEL_START) ? start_q : idx_q;

	assign sum_next = {1'b0, sum_q} + {1'b0, rd_q.width};
	assign idx_end  = (idx_q >= len_q);

	// Break at the scan end when in glyph mode, at the text end, or when the
	// stopping glyph opens a new space run; otherwise keep the last run start.
	always_comb begin
		if (mode_q || idx_end || (rd_q.flag && !in_sp_q)) begin
			brk_fin = idx_q;
		end else begin
			brk_fin = brk_q;
		end
	end

	assign chunk_len = brk_fin - start_q;

	assign sts.start_at_end = (start_q >= len_q);
	assign sts.index_at_end = idx_end;
	assign sts.rd_space     = rd_q.flag;
	assign sts.fits         = (sum_next < {1'b0, max_sp_q});
	assign sts.skip_left    = skip_q && !mode_q;
	assign sts.word_mode    = !mode_q;
	assign sts.chunk_ok     = (chunk_len != '0);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wr_base[ADDR_W-1:0]] <= '{flag: (glyph_code == SPACE_CODE),
				width: glyph_width};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem_q[rd_addr[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			start_q <= '0;
			mode_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_data;
			end
			if (wr_ok) begin
				len_q <= wr_base + CNT_W'(1);
			end
			if (cmd.load && start_new_text) begin
				start_q <= '0;
			end else if (cmd.start_inc) begin
				start_q <= start_q + CNT_W'(1);
			end else if (cmd.res == RES_FINAL && sts.chunk_ok) begin
				start_q <= brk_fin;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			max_sp_q <= max_space;
			skip_q   <= remove_left_spaces;
		end
		if (cmd.scan_init) begin
			idx_q   <= start_q;
			brk_q   <= start_q;
			sum_q   <= '0;
			in_sp_q <= 1'b0;
		end else if (cmd.scan_step) begin
			// Remember where the latest space run began.
			if (rd_q.flag) begin
				if (!in_sp_q) begin
					brk_q <= idx_q;
				end
				in_sp_q <= 1'b1;
			end else begin
				in_sp_q <= 1'b0;
			end
			sum_q <= sum_next[WIDTH_W-1:0];
			idx_q <= idx_q + CNT_W'(1);
		end
		case (cmd.res)
			RES_FINAL: begin
				if (sts.chunk_ok) begin
					res_status <= ST_CHUNK;
					res_start  <= start_q[ADDR_W-1:0];
					res_length <= chunk_len;
					res_break  <= !idx_end;
				end else begin
					res_status <= ST_NOFIT;
					res_start  <= '0;
					res_length <= '0;
					res_break  <= 1'b0;
				end
			end
			RES_END: begin
				res_status <= ST_END;
				res_start  <= '0;
				res_length <= '0;
				res_break  <= 1'b0;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- src/gtls_ctrl.sv -----
module gtls_ctrl import gtls_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	input  logic item_operation,
	output logic item_ready,
	input  logic result_ready,
	output logic result_valid,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q;
	state_t state_next;
	logic   valid_q;
	logic   out_free;

	assign out_free     = !valid_q || result_ready;
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.res != RES_NONE) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item_operation == OP_REQUEST) begin
						cmd.latch_req = 1'b1;
						state_next    = S_CHECK;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_CHECK: begin
				if (sts.start_at_end) begin
					state_next = S_END_OUT;
				end else if (sts.skip_left) begin
					state_next = S_PRE_RD;
				end else begin
					cmd.scan_init = 1'b1;
					state_next    = S_SCAN_RD;
				end
			end
			S_PRE_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = SEL_START;
				state_next = S_PRE_EV;
			end
			S_PRE_EV: begin
				// Drop a leading space and recheck the text end.
				if (sts.rd_space) begin
					cmd.start_inc = 1'b1;
					state_next    = S_CHECK;
				end else begin
					cmd.scan_init = 1'b1;
					state_next    = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				if (sts.index_at_end) begin
					state_next = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = SEL_INDEX;
					state_next = S_SCAN_EV;
				end
			end
			S_SCAN_EV: begin
				if (sts.fits) begin
					cmd.scan_step = 1'b1;
					state_next    = S_SCAN_RD;
				end else begin
					state_next = S_FINISH;
				end
			end
			S_FINISH: begin
				// Hold until the result register is free.
				if (out_free) begin
					cmd.res = RES_FINAL;
					if (sts.word_mode && sts.chunk_ok) begin
						state_next = S_POST_CK;
					end else begin
						state_next = S_IDLE;
					end
				end
			end
			S_END_OUT: begin
				if (out_free) begin
					cmd.res    = RES_END;
					state_next = S_IDLE;
				end
			end
			S_POST_CK: begin
				if (sts.start_at_end) begin
					state_next = S_IDLE;
				end else begin
					state_next = S_POST_RD;
				end
			end
			S_POST_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = SEL_START;
				state_next = S_POST_EV;
			end
			S_POST_EV: begin
				// Skip spaces that trail the chunk.
				if (sts.rd_space) begin
					cmd.start_inc = 1'b1;
					state_next    = S_POST_CK;
				end else begin
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

endmodule

// ----- src/gtls_checker.sv -----
module gtls_checker import gtls_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic              item_operation,
	input logic              result_valid,
	input logic              result_ready,
	input logic [1:0]        result_status,
	input logic [ADDR_W-1:0] chunk_start,
	input logic [CNT_W-1:0]  chunk_length,
	input logic              break_requested
);

`include "greedy_text_line_splitter_assert.svh"

	`GTLS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result dropped while stalled")

	// A chunk request keeps the input closed for at least the next cycle.
	`GTLS_ASSERT_NEXT(a_request_busy, item_valid && item_ready && (item_operation == OP_REQUEST), !item_ready, "input open right after a chunk request")

	`GTLS_ASSERT_NOW(a_empty_fields, result_valid && (result_status != ST_CHUNK), (chunk_start == '0) && (chunk_length == '0) && !break_requested, "non-chunk result carries chunk fields")

	`GTLS_ASSERT_NOW(a_chunk_nonzero, result_valid && (result_status == ST_CHUNK), chunk_length != '0, "chunk result with zero length")

endmodule

bind greedy_text_line_splitter gtls_checker u_gtls_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.item_valid      (item.valid),
	.item_ready      (item.ready),
	.item_operation  (item.operation),
	.result_valid    (result.valid),
	.result_ready    (result.ready),
	.result_status   (result.status),
	.chunk_start     (result.chunk_start),
	.chunk_length    (result.chunk_length),
	.break_requested (result.break_requested)
);

// ----- tb/greedy_text_line_splitter_tb.sv -----
`timescale 1ns / 100ps

module greedy_text_line_splitter_tb import gtls_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 60000;
	localparam int SETTLE_CYCLES  = 10;
	localparam int RANDOM_ITEMS   = 400;
	localparam int MAX_PRINTED    = 30;

	typedef struct {
		status_t            status;
		logic [ADDR_W-1:0]  chunk_start;
		logic [CNT_W-1:0]   chunk_length;
		logic               break_requested;
	} chunk_t;

	class chunk_tracker;
		bit                 is_space [MAX_GLYPHS];
		logic [WIDTH_W-1:0] adv [MAX_GLYPHS];
		int                 text_len;
		int                 start_pos;
		bit                 glyph_mode;
		chunk_t             chunks_due [$];
		int                 errors;

		function new();
			text_len   = 0;
			start_pos  = 0;
			glyph_mode = 1'b0;
			errors     = 0;
		endfunction

		task report_mismatch(input string msg);
			if (errors < MAX_PRINTED)
				$display("mismatch @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function void skip_spaces();
			while (start_pos < text_len && is_space[start_pos])
				start_pos++;
		endfunction

		function void take_request(input op_t op, input logic fresh,
				input logic [CODE_W-1:0] code, input logic [WIDTH_W-1:0] w,
				input logic [WIDTH_W-1:0] lim, input logic skip);
			chunk_t     r;
			int         pos;
			int         cut;
			logic [63:0] acc;
			bit         in_run;
			if (op == OP_LOAD) begin
				if (fresh) begin
					text_len  = 0;
					start_pos = 0;
				end
				// drop the glyph once the store is full
				if (text_len < MAX_GLYPHS) begin
					is_space[text_len] = (code == SPACE_CODE);
					adv[text_len]      = w;
					text_len++;
				end
				return;
			end
			r = '{ST_END, '0, '0, 1'b0};
			if (!glyph_mode && skip)
				skip_spaces();
			if (start_pos >= text_len) begin
				chunks_due.push_back(r);
				return;
			end
			pos    = start_pos;
			cut    = start_pos;
			acc    = '0;
			in_run = 1'b0;
			while (pos < text_len && acc + 64'(adv[pos]) < 64'(lim)) begin
				if (is_space[pos]) begin
					// break point is the first space of the latest run
					if (!in_run) begin
						cut    = pos;
						in_run = 1'b1;
					end
				end else begin
					in_run = 1'b0;
				end
				acc += 64'(adv[pos]);
				pos++;
			end
			if (glyph_mode || pos == text_len || (is_space[pos] && !in_run))
				cut = pos;
			if (cut == start_pos) begin
				r.status = ST_NOFIT;
			end else begin
				r.status          = ST_CHUNK;
				r.chunk_start     = ADDR_W'(start_pos);
				r.chunk_length    = CNT_W'(cut - start_pos);
				r.break_requested = (pos < text_len);
				start_pos         = cut;
				if (!glyph_mode)
					skip_spaces();
			end
			chunks_due.push_back(r);
		endfunction

		task check_chunk(input status_t status, input logic [ADDR_W-1:0] first,
				input logic [CNT_W-1:0] count, input logic brk);
			chunk_t want;
			if (chunks_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d start=%0d len=%0d",
					status, first, count));
				return;
			end
			want = chunks_due.pop_front();
			if (status !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", status, want.status));
			if (first !== want.chunk_start)
				report_mismatch($sformatf("chunk_start %0d, want %0d", first, want.chunk_start));
			if (count !== want.chunk_length)
				report_mismatch($sformatf("chunk_length %0d, want %0d",
					count, want.chunk_length));
			if (brk !== want.break_requested)
				report_mismatch($sformatf("break_requested %0b, want %0b",
					brk, want.break_requested));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_data;

	gtls_in_if  item_bus ();
	gtls_out_if result_bus ();

	greedy_text_line_splitter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_bus),
		.result   (result_bus),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	chunk_tracker tracker;
	bit  tx_idle_on;
	bit  rx_idle_on;
	int  rx_hold_req;
	int  items_sent;
	int  idle_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	function automatic logic [CODE_W-1:0] pick_code();
		if ($urandom_range(0, 3) == 0)
			return SPACE_CODE;
		return CODE_W'($urandom_range(0, 21'h10FFFF));
	endfunction

	function automatic logic [WIDTH_W-1:0] pick_width(input int base);
		int r;
		r = $urandom_range(0, 29);
		if (r == 0)
			return '0;
		if (r == 1)
			return WIDTH_W'($urandom);
		return WIDTH_W'($urandom_range(base / 2, base + base / 2));
	endfunction

	function automatic logic [WIDTH_W-1:0] pick_limit(input int base);
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return '0;
			1: return '1;
			2: return WIDTH_W'($urandom);
			default: return WIDTH_W'($urandom_range(0, base * 10));
		endcase
	endfunction

	task automatic idle_tx(input int n);
		repeat (n) begin
			@(negedge clk);
			item_bus.valid <= 1'b0;
		end
	endtask

	// hold the request until the block takes it, then log it
	task automatic send(input op_t op, input logic fresh, input logic [CODE_W-1:0] code,
			input logic [WIDTH_W-1:0] w, input logic [WIDTH_W-1:0] lim, input logic skip);
		@(negedge clk);
		item_bus.valid              <= 1'b1;
		item_bus.operation          <= op;
		item_bus.start_new_text     <= fresh;
		item_bus.glyph_code         <= code;
		item_bus.glyph_width        <= w;
		item_bus.max_space          <= lim;
		item_bus.remove_left_spaces <= skip;
		do
			@(posedge clk);
		while (item_bus.ready !== 1'b1);
		tracker.take_request(op, fresh, code, w, lim, skip);
		items_sent++;
		if (tx_idle_on && $urandom_range(0, 3) == 0)
			idle_tx(pick_gap());
	endtask

	task automatic load_glyph(input logic fresh, input logic [CODE_W-1:0] code,
			input logic [WIDTH_W-1:0] w);
		send(OP_LOAD, fresh, code, w, WIDTH_W'($urandom), 1'($urandom));
	endtask

	task automatic ask_chunk(input logic [WIDTH_W-1:0] lim, input logic skip);
		send(OP_REQUEST, 1'($urandom), CODE_W'($urandom), WIDTH_W'($urandom), lim, skip);
	endtask

	task automatic wait_results_done();
		idle_tx(1);
		while (tracker.chunks_due.size() != 0)
			@(posedge clk);
		// a trailing load may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input bit mode);
		wait_results_done();
		@(negedge clk);
		cfg_we             <= 1'b1;
		cfg_data           <= mode;
		tracker.glyph_mode  = mode;
		@(negedge clk);
		cfg_we             <= 1'b0;
	endtask

	task automatic run_text();
		int n;
		int base;
		int tries;
		n     = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 100) : $urandom_range(1, 30);
		base  = $urandom_range(64, 2048);
		tries = 0;
		for (int k = 0; k < n; k++)
			load_glyph(k == 0, pick_code(), pick_width(base));
		while (tries < n + 4 && tracker.start_pos < tracker.text_len) begin
			ask_chunk(pick_limit(base), 1'($urandom));
			tries++;
		end
		if ($urandom_range(0, 1) == 0)
			ask_chunk(pick_limit(base), 1'($urandom));
	endtask

	task automatic run_noise();
		repeat ($urandom_range(4, 10))
			send(op_t'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
				pick_code(), WIDTH_W'($urandom), WIDTH_W'($urandom), 1'($urandom));
	endtask

	task automatic receive_results();
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
				tracker.check_chunk(result_bus.status, result_bus.chunk_start,
					result_bus.chunk_length, result_bus.break_requested);
			@(negedge clk);
			if (rx_hold_req > 0) begin
				stall       = rx_hold_req;
				rx_hold_req = 0;
			end else if (stall == 0 && rx_idle_on && $urandom_range(0, 3) == 0) begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				result_bus.ready <= 1'b0;
				stall--;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	endtask

	initial begin
		result_bus.ready = 1'b0;
		@(posedge arst_n);
		receive_results();
	end

	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
					(result_bus.valid === 1'b1 && result_bus.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[greedy_text_line_splitter] ERROR");
		$finish;
	end

	initial begin
		int start_count;
		int phase;
		tracker                     = new();
		tx_idle_on                  = 1'b0;
		rx_idle_on                  = 1'b0;
		rx_hold_req                 = 0;
		items_sent                  = 0;
		arst_n                      = 1'b0;
		cfg_we                      = 1'b0;
		cfg_data                    = 1'b0;
		item_bus.valid              = 1'b0;
		item_bus.operation          = OP_LOAD;
		item_bus.start_new_text     = 1'b0;
		item_bus.glyph_code         = '0;
		item_bus.glyph_width        = '0;
		item_bus.max_space          = '0;
		item_bus.remove_left_spaces = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// word mode from reset: empty text first
		ask_chunk('1, 1'b1);
		load_glyph(1'b1, SPACE_CODE, 24'd256);
		load_glyph(1'b0, CODE_W'(65), 24'd256);
		load_glyph(1'b0, CODE_W'(66), 24'd256);
		load_glyph(1'b0, SPACE_CODE, 24'd256);
		load_glyph(1'b0, SPACE_CODE, 24'd256);
		load_glyph(1'b0, CODE_W'(67), 24'd256);
		load_glyph(1'b0, CODE_W'(68), 24'd256);
		load_glyph(1'b0, SPACE_CODE, 24'd256);
		ask_chunk(24'd512, 1'b0);
		ask_chunk(24'd1024, 1'b1);
		ask_chunk('1, 1'b0);
		ask_chunk('0, 1'b0);
		// text of spaces only, skipped away
		load_glyph(1'b1, SPACE_CODE, 24'd1);
		load_glyph(1'b0, SPACE_CODE, 24'd1);
		ask_chunk('1, 1'b1);
		// widest glyphs against the widest line
		load_glyph(1'b1, CODE_W'(21'h10FFFF), '1);
		load_glyph(1'b0, '0, '1);
		ask_chunk('1, 1'b0);
		set_mode(1'b1);
		ask_chunk('1, 1'b0);
		ask_chunk('0, 1'b1);

		start_count = items_sent;
		phase       = 0;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			set_mode(phase < 2 ? phase[0] : 1'($urandom));
			tx_idle_on = $urandom_range(0, 3) != 0;
			rx_idle_on = $urandom_range(0, 3) != 0;
			if (phase == 0) begin
				// stall the result side long enough to back up the input
				tx_idle_on  = 1'b0;
				rx_hold_req = 300;
			end
			repeat (3) begin
				if ($urandom_range(0, 19) < 17)
					run_text();
				else
					run_noise();
				if ($urandom_range(0, 3) == 0)
					wait_results_done();
			end
			phase++;
		end

		wait_results_done();
		repeat (40) @(posedge clk);
		if (tracker.errors == 0)
			$display("[greedy_text_line_splitter] OK");
		else
			$display("[greedy_text_line_splitter] ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+src
src/gtls_pkg.sv
src/gtls_in_if.sv
src/gtls_out_if.sv
src/gtls_datapath.sv
src/gtls_ctrl.sv
src/greedy_text_line_splitter.sv
src/gtls_checker.sv
tb/greedy_text_line_splitter_tb.sv
